// ===== src/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// shared types, constants and digit helpers for the radix digit emitter
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 11;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned QDEC_W     = 29;
  localparam int unsigned QDEC_SHIFT = 35;

  localparam logic [MODE_W-1:0] MODE_OCT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEC     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX_LOW = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HEX_UP  = 2'd3;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 8'h61;

  // reciprocal of ten, scaled by 2^35
  localparam logic [VALUE_W-1:0] RECIP_DEC = 32'hCCCC_CCCD;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_dec;
  } cmd_t;

  typedef struct packed {
    logic q_zero;
    logic ptr_zero;
  } status_t;

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] digit,
                                               input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UPPER : ASCII_LOWER;
    if (digit < DIGIT_W'(10)) begin
      return ASCII_ZERO + CHAR_W'(digit);
    end
    return base + CHAR_W'(digit - DIGIT_W'(10));
  endfunction

endpackage

// ===== src/rde_datapath.sv =====
// ----------------------------------------------------------------------------
// rde_datapath
// value register, reciprocal multiplier, digit extraction and digit buffer
// ----------------------------------------------------------------------------
module rde_datapath import rde_pkg::*; (
  input  logic                clk,
  input  cmd_t                cmd,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [MODE_W-1:0]   in_mode,
  output status_t             status,
  output logic [CHAR_W-1:0]   digit_char,
  output logic                last
);

  logic [VALUE_W-1:0]   value_r;
  logic [MODE_W-1:0]    mode_r;
  logic [QDEC_W-1:0]    qdec_r;
  logic [IDX_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     ptr_r;
  logic [CHAR_W-1:0]    buf_r [MAX_DIGITS];

  logic [2*VALUE_W-1:0] product;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   qdec_ext;
  logic [VALUE_W-1:0]   qdec_x10;
  logic [VALUE_W-1:0]   rem_dec;
  logic [DIGIT_W-1:0]   digit;

  assign product  = {{VALUE_W{1'b0}}, value_r} * {{VALUE_W{1'b0}}, RECIP_DEC};
  assign qdec_ext = VALUE_W'(qdec_r);
  assign qdec_x10 = (qdec_ext << 3) + (qdec_ext << 1);
  assign rem_dec  = value_r - qdec_x10;

  always_comb begin
    case (mode_r)
      MODE_OCT: begin
        quot  = value_r >> 3;
        digit = {1'b0, value_r[2:0]};
      end
      MODE_DEC: begin
        quot  = qdec_ext;
        digit = rem_dec[DIGIT_W-1:0];
      end
      default: begin
        quot  = value_r >> 4;
        digit = value_r[DIGIT_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    qdec_r <= product[QDEC_SHIFT +: QDEC_W];
    if (cmd.load) begin
      value_r <= in_value;
      mode_r  <= in_mode;
      cnt_r   <= '0;
    end else if (cmd.step) begin
      buf_r[cnt_r] <= char_of(digit, mode_r == MODE_HEX_UP);
      value_r      <= quot;
      cnt_r        <= cnt_r + IDX_W'(1);
      ptr_r        <= cnt_r;
    end else if (cmd.emit_dec) begin
      ptr_r <= ptr_r - IDX_W'(1);
    end
  end

  assign status.q_zero   = (quot == '0);
  assign status.ptr_zero = (ptr_r == '0);
  assign digit_char      = buf_r[ptr_r];
  assign last            = (ptr_r == '0);

endmodule

// ===== src/rde_ctrl.sv =====
// ----------------------------------------------------------------------------
// rde_ctrl
// sequencer: accept, one digit per multiply and step pair, then emit
// ----------------------------------------------------------------------------
module rde_ctrl import rde_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_STEP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load     = 1'b1;
          state_nxt    = S_MUL;
          in_ready_nxt = 1'b0;
        end
      end
      S_MUL: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (status.q_zero) begin
          state_nxt     = S_EMIT;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (status.ptr_zero) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b0;
            in_ready_nxt  = 1'b1;
          end else begin
            cmd.emit_dec = 1'b1;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        in_ready_nxt  = 1'b1;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("input ready while a digit is on offer");

  a_load_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready_r) |=> (state_r == S_MUL))
    else $error("accepted transaction did not start conversion");

  a_mul_to_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_STEP))
    else $error("multiply cycle not followed by digit step");

  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT))
    else $error("output valid outside emit phase");

endmodule

// ===== src/radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter
// unsigned 32-bit value to ascii digits in octal, decimal or hexadecimal
// ----------------------------------------------------------------------------
// One value is converted at a time. After the input transaction each digit
// is made by a registered multiply by the reciprocal of ten, then a digit
// step that also serves the octal and hex shifts, least significant digit
// first into an eleven-entry buffer. The digits are then offered most
// significant first, one per cycle while out_ready is high, with last on the
// final one. The next value is taken in the cycle after the last digit leaves.
module radix_digit_emitter import rde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [MODE_W-1:0]  in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last
);

  cmd_t    cmd;
  status_t status;

  rde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rde_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .in_value   (in_value),
    .in_mode    (in_mode),
    .status     (status),
    .digit_char (out_digit_char),
    .last       (out_last)
  );

endmodule

// ===== test/tb_radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// tb_radix_digit_emitter
// self-checking bench for the integer to ascii radix digit emitter
// ----------------------------------------------------------------------------
// Values go in with their radix mode. Each accepted transaction is expanded
// into the ASCII digits it should produce, most significant first, with the
// last flag on the final digit. Every output transaction is checked against
// the oldest digit still outstanding. A short directed set covers zero,
// all-ones, radix boundaries and all four modes. Random values of varied
// magnitude follow, under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radix_digit_emitter import rde_pkg::*; ();

  class digit_scoreboard;

    typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
    } expected_digit_t;

    expected_digit_t pending_digits[$];
    int unsigned     error_count;
    int unsigned     digits_checked;
    int unsigned     values_per_mode[4];

    // expand one value into its digit characters, most significant digit first
    function void note_value(logic [VALUE_W-1:0] value, logic [MODE_W-1:0] mode);
      int unsigned        radix;
      int unsigned        digit;
      logic [VALUE_W-1:0] rest;
      logic [CHAR_W-1:0]  letter_base;
      expected_digit_t    digits[$];
      expected_digit_t    entry;
      case (mode)
        MODE_OCT: radix = 8;
        MODE_DEC: radix = 10;
        default:  radix = 16;
      endcase
      letter_base = (mode == MODE_HEX_UP) ? ASCII_UPPER : ASCII_LOWER;
      rest = value;
      do begin
        digit = rest % radix;
        entry.ch = (digit < 10) ? ASCII_ZERO + CHAR_W'(digit)
                                : letter_base + CHAR_W'(digit - 10);
        entry.last = 1'b0;
        digits.push_front(entry);
        rest = rest / radix;
      end while (rest != 0);
      digits[digits.size()-1].last = 1'b1;
      foreach (digits[i]) pending_digits.push_back(digits[i]);
      values_per_mode[mode]++;
    endfunction

    function void check_digit(logic [CHAR_W-1:0] ch, logic last);
      expected_digit_t exp_digit;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit transaction, got char %h last %b",
                 $realtime, ch, last);
        error_count++;
        return;
      end
      exp_digit = pending_digits.pop_front();
      digits_checked++;
      if (ch !== exp_digit.ch) begin
        $display("%0t: digit_char mismatch, expected %h, got %h",
                 $realtime, exp_digit.ch, ch);
        error_count++;
      end
      if (last !== exp_digit.last) begin
        $display("%0t: last mismatch, expected %b, got %b",
                 $realtime, exp_digit.last, last);
        error_count++;
      end
    endfunction

  endclass

  localparam int unsigned RANDOM_PER_PHASE = 142;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned DRAIN_CYCLES     = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic [MODE_W-1:0]  in_mode = MODE_OCT;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last;

  int unsigned        tx_idle_pct = 31;
  int unsigned        rx_idle_pct = 81;
  int unsigned        cycle_count = 0;

  digit_scoreboard board = new();

  radix_digit_emitter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d digits outstanding",
               $realtime, board.pending_digits.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_digit(out_digit_char, out_last);
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] value, input logic [MODE_W-1:0] mode);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_mode  <= mode;
    do @(posedge clk); while (!in_ready);
    board.note_value(value, mode);
  endtask

  // hold off the sender until every outstanding digit has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (board.pending_digits.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] value;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero and all-ones in every mode, radix boundaries, widest values
    send_value(32'd0, MODE_OCT);
    send_value(32'd0, MODE_DEC);
    send_value(32'd0, MODE_HEX_LOW);
    send_value(32'd0, MODE_HEX_UP);
    send_value(32'hFFFF_FFFF, MODE_OCT);
    send_value(32'hFFFF_FFFF, MODE_DEC);
    send_value(32'hFFFF_FFFF, MODE_HEX_LOW);
    send_value(32'hFFFF_FFFF, MODE_HEX_UP);
    send_value(32'd1, MODE_DEC);
    send_value(32'd7, MODE_OCT);
    send_value(32'd8, MODE_OCT);
    send_value(32'd9, MODE_DEC);
    send_value(32'd10, MODE_DEC);
    send_value(32'd15, MODE_HEX_LOW);
    send_value(32'd16, MODE_HEX_UP);
    send_value(32'h00AB_CDEF, MODE_HEX_LOW);
    send_value(32'h00AB_CDEF, MODE_HEX_UP);
    send_value(32'd1000000000, MODE_DEC);
    send_value(32'd999999999, MODE_DEC);
    send_value(32'h8000_0000, MODE_OCT);
    send_value(32'h1234_5678, MODE_HEX_UP);
    send_value(32'h4000_0000, MODE_OCT);

    for (int phase = 0; phase < 3; phase++) begin
      wait_for_drain();
      case (phase)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        case ($urandom_range(9))
          0:       value = '0;
          1:       value = '1;
          2, 3, 4: value = $urandom;
          default: value = $urandom >> $urandom_range(31);
        endcase
        send_value(value, MODE_W'($urandom_range(3)));
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_digits.size() != 0) begin
      $display("%0t: %0d digits never arrived", $realtime, board.pending_digits.size());
      board.error_count++;
    end

    $display("converted %0d octal, %0d decimal, %0d lower hex and %0d upper hex values",
             board.values_per_mode[MODE_OCT], board.values_per_mode[MODE_DEC],
             board.values_per_mode[MODE_HEX_LOW], board.values_per_mode[MODE_HEX_UP]);
    $display("%0d digit transactions checked, %0d errors",
             board.digits_checked, board.error_count);
    if (board.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
